/* rtl/core/lepe_pkg.sv */
// lepe_pkg: shared types, codes and constants of the led event pattern engine
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps

package lepe_pkg;

  // fixed field widths
  localparam int TICK_W  = 32;
  localparam int WORD_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int OP_W    = 2;
  localparam int HELD_W  = 5;

  // remainder unit: bits retired per cycle and iteration counts
  localparam int MOD_STEP   = 4;
  localparam int ITER_W     = 4;
  localparam logic [ITER_W-1:0] TICK_ITERS = ITER_W'(TICK_W / MOD_STEP);
  localparam logic [ITER_W-1:0] CNT_ITERS  = ITER_W'(BYTE_W / MOD_STEP);

  // item opcodes
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_SETUP  = 2'd3;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_OFF       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ON        = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BLINK     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SLICE_ON  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SLICE_OFF = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [KIND_W-1:0] event_kind;
    logic [WORD_W-1:0] light_mask;
    logic [BYTE_W-1:0] color;
    logic [BYTE_W-1:0] slice_index;
    logic [BYTE_W-1:0] slice_total;
    logic [BYTE_W-1:0] tick_divider;
    logic [BYTE_W-1:0] start_count;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] light_word;
    logic              status;
    logic [HELD_W-1:0] events_held;
  } result_t;

  // stored event parameters (43 bits)
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] color;
    logic [BYTE_W-1:0] slice;
    logic [BYTE_W-1:0] total;
    logic [BYTE_W-1:0] divider;
    logic [BYTE_W-1:0] count;
  } event_t;

  // controller to datapath
  typedef struct packed {
    logic latch_item;
    logic append;
    logic clear;
    logic setup;
    logic tick_start;
    logic tick_finish;
    logic rd_en;
    logic mod_start;
    logic mod_cnt;
    logic latch_due;
    logic apply;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            more;
    logic            timed;
    logic            is_slice;
    logic            mod_done;
    logic            rem_zero;
  } sts_t;

endpackage

/* rtl/core/lepe_if.sv */
// lepe_if: valid/ready channel interfaces for items, results and configuration
// depends on lepe_pkg for field widths
`timescale 1ns / 1ps

interface lepe_item_if import lepe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [KIND_W-1:0] event_kind;
  logic [WORD_W-1:0] light_mask;
  logic [BYTE_W-1:0] color;
  logic [BYTE_W-1:0] slice_index;
  logic [BYTE_W-1:0] slice_total;
  logic [BYTE_W-1:0] tick_divider;
  logic [BYTE_W-1:0] start_count;

  modport source (output valid, opcode, event_kind, light_mask, color, slice_index,
                  slice_total, tick_divider, start_count, input ready);
  modport sink (input valid, opcode, event_kind, light_mask, color, slice_index,
                slice_total, tick_divider, start_count, output ready);
endinterface

interface lepe_result_if import lepe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] light_word;
  logic              status;
  logic [HELD_W-1:0] events_held;

  modport source (output valid, light_word, status, events_held, input ready);
  modport sink (input valid, light_word, status, events_held, output ready);
endinterface

interface lepe_cfg_if import lepe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/core/led_event_pattern_engine_top.sv */
// led event pattern engine: one result beat per item. register, clear and setup
// items pass from accept through decode and done to the result. a tick walks
// each stored event through read, eval and apply; blink and slice kinds also
// use the 4-bit-per-cycle remainder unit, one-shot and unknown kinds do not.
// one item at a time; the next item is accepted while a result waits.
// reset (rst, synchronous): light word 0, tick count 1, empty table, config 0.
`timescale 1ns / 1ps

module led_event_pattern_engine_top import lepe_pkg::*; #(
  parameter int EVENT_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  lepe_cfg_if.sink    cfg,
  lepe_item_if.sink   item,
  lepe_result_if.source result
);

  item_t   item_data;
  result_t res;
  cmd_t    cmd;
  sts_t    sts;
  logic    item_ready;
  logic    out_valid;

  // configuration is always taken
  assign cfg.ready = 1'b1;

  // item beat into struct form
  assign item_data = '{opcode: item.opcode, event_kind: item.event_kind,
                       light_mask: item.light_mask, color: item.color,
                       slice_index: item.slice_index, slice_total: item.slice_total,
                       tick_divider: item.tick_divider, start_count: item.start_count};
  assign item.ready = item_ready;

  // result beat
  assign result.valid       = out_valid;
  assign result.light_word  = res.light_word;
  assign result.status      = res.status;
  assign result.events_held = res.events_held;

  lepe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .out_valid  (out_valid),
    .res_ready  (result.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lepe_datapath #(
    .EVENT_DEPTH (EVENT_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .item      (item_data),
    .cmd       (cmd),
    .sts       (sts),
    .res       (res)
  );

endmodule

/* rtl/core/lepe_modulo.sv */
// lepe_modulo: iterative remainder of a 32-bit value by an 8-bit divisor
// restoring division, MOD_STEP quotient bits per cycle; depends on lepe_pkg
`timescale 1ns / 1ps

module lepe_modulo import lepe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TICK_W-1:0] dividend,
  input  logic [BYTE_W-1:0] divisor,
  input  logic [ITER_W-1:0] iters,
  output logic              busy,
  output logic [BYTE_W-1:0] rem
);

  logic [TICK_W-1:0] dv;
  logic [BYTE_W-1:0] div;
  logic [ITER_W-1:0] left;
  logic [BYTE_W-1:0] rem_next;

  // MOD_STEP restoring steps on the running remainder
  always_comb begin
    logic [BYTE_W:0] r9;
    r9 = '0;
    rem_next = rem;
    for (int k = 0; k < MOD_STEP; k++) begin
      r9 = {rem_next, dv[TICK_W-1-k]};
      if (r9 >= {1'b0, div}) begin
        r9 = r9 - {1'b0, div};
      end
      rem_next = r9[BYTE_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      left <= '0;
    end else if (start) begin
      busy <= 1'b1;
      left <= iters;
    end else if (busy) begin
      left <= left - ITER_W'(1);
      if (left == ITER_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // operands and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dv  <= dividend;
      div <= divisor;
      rem <= '0;
    end else if (busy) begin
      dv  <= dv << MOD_STEP;
      rem <= rem_next;
    end
  end

  // remainder stays below the divisor while working
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < div) else $error("remainder out of range");

endmodule

/* rtl/core/lepe_datapath.sv */
// lepe_datapath: light word, tick count, event table memory and event evaluation
// depends on lepe_pkg and lepe_modulo; driven by lepe_ctrl commands
`timescale 1ns / 1ps

module lepe_datapath import lepe_pkg::*; #(
  parameter int EVENT_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [WORD_W-1:0] cfg_data,
  input  item_t             item,
  input  cmd_t              cmd,
  output sts_t              sts,
  output result_t           res
);

  localparam int IDX_W = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int CNT_W = $clog2(EVENT_DEPTH + 1);

  logic [WORD_W-1:0] initial_lights;
  logic [WORD_W-1:0] light;
  logic [TICK_W-1:0] tick_count;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  i;
  logic [CNT_W-1:0]  w;
  logic              status;
  logic              due;
  item_t             item_q;

  logic [WORD_W-1:0] mask_mem [EVENT_DEPTH];
  event_t            ev_mem [EVENT_DEPTH];
  logic [WORD_W-1:0] mask_q;
  event_t            ev_q;
  logic [WORD_W-1:0] lowbit;

  logic              full;
  logic              mem_we;
  logic [IDX_W-1:0]  wa;
  logic [WORD_W-1:0] mask_wd;
  event_t            ev_wd;

  logic [BYTE_W-1:0] div_eff;
  logic [BYTE_W-1:0] tot_eff;
  logic [TICK_W-1:0] mod_dividend;
  logic [BYTE_W-1:0] mod_divisor;
  logic [ITER_W-1:0] mod_iters;
  logic              mod_busy;
  logic [BYTE_W-1:0] mod_rem;

  logic [BYTE_W-1:0]        color_sel;
  logic                     do_write;
  logic                     keep;
  logic                     hit;
  event_t                   ev_upd;
  logic [WORD_W-1:0]        placed;
  logic [WORD_W-1:0]        light_new;

  assign full = (total == CNT_W'(EVENT_DEPTH));

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_lights <= '0;
    end else if (cfg_valid) begin
      initial_lights <= cfg_data;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_q <= item;
    end
  end

  // remainder unit operands, zero divisor or total counts as one
  assign div_eff = (ev_q.divider == '0) ? BYTE_W'(1) : ev_q.divider;
  assign tot_eff = (ev_q.total == '0) ? BYTE_W'(1) : ev_q.total;
  assign mod_dividend = cmd.mod_cnt ? {ev_q.count, {(TICK_W-BYTE_W){1'b0}}} : tick_count;
  assign mod_divisor  = cmd.mod_cnt ? tot_eff : div_eff;
  assign mod_iters    = cmd.mod_cnt ? CNT_ITERS : TICK_ITERS;

  lepe_modulo u_modulo (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .iters    (mod_iters),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_due) begin
      due <= (mod_rem == '0);
    end
  end

  // lowest set bit of the event mask
  always_ff @(posedge clk) begin
    lowbit <= mask_q & (~mask_q + WORD_W'(1));
  end

  // event evaluation
  always_comb begin
    color_sel = '0;
    do_write  = 1'b0;
    keep      = 1'b0;
    hit       = (mod_rem == ev_q.slice);
    ev_upd    = ev_q;
    unique case (ev_q.kind)
      KIND_OFF: begin
        do_write = 1'b1;
      end
      KIND_ON: begin
        do_write  = 1'b1;
        color_sel = ev_q.color;
      end
      KIND_BLINK: begin
        keep      = 1'b1;
        do_write  = due;
        color_sel = ((light & mask_q) != '0) ? '0 : ev_q.color;
      end
      KIND_SLICE_ON, KIND_SLICE_OFF: begin
        keep     = 1'b1;
        do_write = due;
        if ((ev_q.kind == KIND_SLICE_ON) ? hit : !hit) begin
          color_sel = ev_q.color;
        end
        if (due) begin
          ev_upd.count = ev_q.count + BYTE_W'(1);
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // color placed at the mask's lowest set bit
  assign placed    = WORD_W'(color_sel) * lowbit;
  assign light_new = (light & ~mask_q) | (placed & mask_q);

  // light word and tick count
  always_ff @(posedge clk) begin
    if (rst) begin
      light      <= '0;
      tick_count <= TICK_W'(1);
    end else if (cmd.setup) begin
      light      <= initial_lights;
      tick_count <= TICK_W'(1);
    end else begin
      if (cmd.tick_start) begin
        tick_count <= tick_count + TICK_W'(1);
      end
      if (cmd.apply && do_write) begin
        light <= light_new;
      end
    end
  end

  // table fill and walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      i     <= '0;
      w     <= '0;
    end else begin
      if (cmd.append && !full) begin
        total <= total + CNT_W'(1);
      end
      if (cmd.clear) begin
        total <= '0;
      end
      if (cmd.tick_start) begin
        i <= '0;
        w <= '0;
      end
      if (cmd.apply) begin
        i <= i + CNT_W'(1);
        if (keep) begin
          w <= w + CNT_W'(1);
        end
      end
      if (cmd.tick_finish) begin
        total <= w;
      end
    end
  end

  // drop status
  always_ff @(posedge clk) begin
    if (rst) begin
      status <= 1'b0;
    end else if (cmd.latch_item) begin
      status <= 1'b0;
    end else if (cmd.append && full) begin
      status <= 1'b1;
    end
  end

  // event table write port: append or compacting write-back
  assign mem_we  = (cmd.append && !full) || (cmd.apply && keep);
  assign wa      = cmd.apply ? w[IDX_W-1:0] : total[IDX_W-1:0];
  assign mask_wd = cmd.apply ? mask_q : item_q.light_mask;
  assign ev_wd   = cmd.apply ? ev_upd : event_t'{kind: item_q.event_kind,
                                                 color: item_q.color,
                                                 slice: item_q.slice_index,
                                                 total: item_q.slice_total,
                                                 divider: item_q.tick_divider,
                                                 count: item_q.start_count};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mask_mem[wa] <= mask_wd;
      ev_mem[wa]   <= ev_wd;
    end
    if (cmd.rd_en) begin
      mask_q <= mask_mem[i[IDX_W-1:0]];
      ev_q   <= ev_mem[i[IDX_W-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res.light_word  <= light;
      res.status      <= status;
      res.events_held <= HELD_W'(total);
    end
  end

  // status to the controller
  assign sts.opcode   = item_q.opcode;
  assign sts.more     = (i < total);
  assign sts.timed    = (ev_q.kind == KIND_BLINK) || (ev_q.kind == KIND_SLICE_ON) ||
                        (ev_q.kind == KIND_SLICE_OFF);
  assign sts.is_slice = (ev_q.kind == KIND_SLICE_ON) || (ev_q.kind == KIND_SLICE_OFF);
  assign sts.mod_done = !mod_busy;
  assign sts.rem_zero = (mod_rem == '0);

  // write-back never overtakes the read pointer
  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    w <= i) else $error("write-back pointer ahead of read pointer");

  // table never holds more than its depth
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(EVENT_DEPTH)) else $error("event count beyond table depth");

endmodule

/* rtl/core/lepe_ctrl.sv */
// lepe_ctrl: controller state machine sequencing item decode and the tick walk
// depends on lepe_pkg; commands lepe_datapath and owns the result valid flag
`timescale 1ns / 1ps

module lepe_ctrl import lepe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  output logic out_valid,
  input  logic res_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_MODT   = 3'd4;
  localparam logic [2:0] S_MODC   = 3'd5;
  localparam logic [2:0] S_APPLY  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.opcode)
          OP_TICK: begin
            cmd.tick_start = 1'b1;
            state_next     = S_READ;
          end
          OP_APPEND: begin
            cmd.append = 1'b1;
            state_next = S_DONE;
          end
          OP_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_DONE;
          end
          OP_SETUP: begin
            cmd.setup  = 1'b1;
            state_next = S_DONE;
          end
        endcase
      end
      S_READ: begin
        if (sts.more) begin
          cmd.rd_en  = 1'b1;
          state_next = S_EVAL;
        end else begin
          cmd.tick_finish = 1'b1;
          state_next      = S_DONE;
        end
      end
      S_EVAL: begin
        if (sts.timed) begin
          cmd.mod_start = 1'b1;
          state_next    = S_MODT;
        end else begin
          state_next = S_APPLY;
        end
      end
      S_MODT: begin
        if (sts.mod_done) begin
          cmd.latch_due = 1'b1;
          if (sts.is_slice && sts.rem_zero) begin
            cmd.mod_start = 1'b1;
            cmd.mod_cnt   = 1'b1;
            state_next    = S_MODC;
          end else begin
            state_next = S_APPLY;
          end
        end
      end
      S_MODC: begin
        if (sts.mod_done) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_READ;
      end
      S_DONE: begin
        if (!out_valid || res_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (res_ready) begin
      out_valid <= 1'b0;
    end
  end

  // a started remainder reports busy on the next cycle
  a_mod_started: assert property (@(posedge clk) disable iff (rst)
    cmd.mod_start |=> !sts.mod_done) else $error("remainder unit did not start");

  // a new result appears only out of the finishing state
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE) else $error("result loaded out of order");

endmodule
